// ----- rtl/pmid_pkg.sv -----
// Shared constants and types for the minimum-image distance pipeline.
package pmid_pkg;

    localparam int COORD_FRAC_BITS   = 20;
    localparam int LATTICE_FRAC_BITS = 10;

    localparam int COORD_W  = 20;
    localparam int LAT_W    = 20;
    localparam int ROW_W    = 3 * LAT_W;
    localparam int DELTA_W  = COORD_FRAC_BITS + 1;
    localparam int PROD_W   = DELTA_W + LAT_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int CART_FRAC = 16;
    localparam int OUT_FRAC  = 12;
    localparam int RND_SHIFT = COORD_FRAC_BITS + LATTICE_FRAC_BITS - CART_FRAC;
    localparam int MAG_W    = CART_FRAC + 12;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int RAD_W    = SUM_W - 2 * (CART_FRAC - OUT_FRAC);
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int DIST_W   = 24;
    localparam int IDX_W    = 2;

    // image stage + 3 cartesian stages + square + sum + root steps + output
    localparam int PIPE_LAT = 7 + ROOT_W;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_A = 2'd0,
        REG_ROW_B = 2'd1,
        REG_ROW_C = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic [MAG_W-1:0]          mag_t;

    typedef struct packed {
        logic             sat;
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } root_state_t;

endpackage

// ----- rtl/pmid_image.sv -----
// Nearest periodic image selection on one axis, registered.
module pmid_image
    import pmid_pkg::*;
(
    input  logic               clk,
    input  logic [COORD_W-1:0] center,
    input  logic [COORD_W-1:0] partner,
    output delta_t             delta_reg
);
    localparam logic signed [DELTA_W-1:0] HALF = DELTA_W'(1) <<< (COORD_FRAC_BITS - 1);
    localparam logic signed [DELTA_W-1:0] ONE  = DELTA_W'(1) <<< COORD_FRAC_BITS;

    delta_t d;
    delta_t delta_next;

    always_comb
    begin
        d = $signed({1'b0, center[COORD_FRAC_BITS-1:0]})
          - $signed({1'b0, partner[COORD_FRAC_BITS-1:0]});
        // ties at exactly half keep the original image
        priority if (d < -HALF)
        begin
            delta_next = d + ONE;
        end
        else if (d > HALF)
        begin
            delta_next = d - ONE;
        end
        else
        begin
            delta_next = d;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
    end
endmodule

// ----- rtl/pmid_cart.sv -----
// Fractional to cartesian transform: multiply, accumulate, round magnitude.
module pmid_cart
    import pmid_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  delta_t           delta [3],
    input  logic [ROW_W-1:0] rows  [3],
    output logic             out_valid,
    output mag_t             mag   [3],
    output logic             sat
);
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [ACC_W-1:0]  acc_reg  [3];
    mag_t                     mag_reg  [3];
    logic                     sat_reg;
    logic [2:0]               vld_reg;

    logic [ACC_W-1:0]         abs_v   [3];
    logic [ACC_W-1:0]         rnd_v   [3];
    mag_t                     mag_next [3];
    logic                     sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // stage: nine products delta_i * row_i[j]
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[i][j] <= PROD_W'(delta[i] * $signed(rows[i][LAT_W*j +: LAT_W]));
            end
        end
    end

    // stage: column sums
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            acc_reg[j] <= ACC_W'(prod_reg[0][j]) + ACC_W'(prod_reg[1][j])
                        + ACC_W'(prod_reg[2][j]);
        end
    end

    // stage: magnitude, round half away from zero, range check
    always_comb
    begin
        sat_next = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            abs_v[j]    = acc_reg[j][ACC_W-1] ? ACC_W'(-acc_reg[j]) : ACC_W'(acc_reg[j]);
            rnd_v[j]    = (abs_v[j] + (ACC_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
            mag_next[j] = rnd_v[j][MAG_W-1:0];
            if (rnd_v[j][ACC_W-1:MAG_W] != '0)
            begin
                sat_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        sat_reg <= sat_next;
    end

    assign out_valid = vld_reg[2];
    assign mag       = mag_reg;
    assign sat       = sat_reg;
endmodule

// ----- rtl/pmid_root_step.sv -----
// One registered digit step of the integer square root.
module pmid_root_step
    import pmid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  root_state_t in_st,
    output logic        out_valid,
    output root_state_t out_st
);
    logic        vld_reg;
    root_state_t st_reg;
    root_state_t st_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        rem_sh  = {in_st.rem[REM_W-3:0], in_st.rad[RAD_W-1 -: 2]};
        trial   = {in_st.root, 2'b01};
        st_next = in_st;
        st_next.rad = {in_st.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            st_next.rem  = rem_sh - trial;
            st_next.root = {in_st.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            st_next.rem  = rem_sh;
            st_next.root = {in_st.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign out_valid = vld_reg;
    assign out_st    = st_reg;
endmodule

// ----- rtl/pmid_root.sv -----
// Squares, sum, and pipelined digit-by-digit square root.
module pmid_root
    import pmid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mag_t              mag [3],
    input  logic              in_sat,
    output logic              out_valid,
    output logic              out_sat,
    output logic [ROOT_W-1:0] root
);
    logic [SQ_W-1:0]  sq_reg [3];
    logic             sat1_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             sat2_reg;
    logic [1:0]       vld_reg;

    logic        vld_chain [ROOT_W+1];
    root_state_t st_chain  [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            sq_reg[j] <= SQ_W'(mag[j] * mag[j]);
        end
        sat1_reg <= in_sat;
        sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        sat2_reg <= sat1_reg;
    end

    always_comb
    begin
        vld_chain[0]     = vld_reg[1];
        st_chain[0].sat  = sat2_reg;
        st_chain[0].rad  = sum_reg[SUM_W-1 -: RAD_W];
        st_chain[0].rem  = '0;
        st_chain[0].root = '0;
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        pmid_root_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld_chain[k]),
            .in_st     (st_chain[k]),
            .out_valid (vld_chain[k+1]),
            .out_st    (st_chain[k+1])
        );
    end

    assign out_valid = vld_chain[ROOT_W];
    assign out_sat   = st_chain[ROOT_W].sat;
    assign root      = st_chain[ROOT_W].root;
endmodule

// ----- rtl/periodic_min_image_distance_top.sv -----
// Top level of the minimum-image periodic distance pipeline.
//
// channel | signals                                  | handshake
// --------+------------------------------------------+---------------------------
// request | start, busy, center_*, partner_* (20b)   | taken when start & !busy
// result  | done, distance (Q12.12), saturated       | one-cycle strobe on done
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data| write when valid & ready
//
// A new request is taken every cycle; busy stays low. Each result passes
// through image select, three cartesian stages, square, sum, one stage per root
// bit (25) and the output register. Latency is set by the bit-per-stage
// square root.
// Reset clears the lattice rows and all valid bits; payload is not reset.
// The receiver cannot stall, so nothing in the pipe ever holds.
module periodic_min_image_distance_top
    import pmid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COORD_W-1:0] center_x,
    input  logic [COORD_W-1:0] center_y,
    input  logic [COORD_W-1:0] center_z,
    input  logic [COORD_W-1:0] partner_x,
    input  logic [COORD_W-1:0] partner_y,
    input  logic [COORD_W-1:0] partner_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [ROW_W-1:0]   cfg_data,
    output logic               done,
    output logic [DIST_W-1:0]  distance,
    output logic               saturated
);
    logic [ROW_W-1:0] row_reg [3];
    logic             img_vld_reg;
    delta_t           delta [3];

    logic             cart_vld;
    mag_t             cart_mag [3];
    logic             cart_sat;

    logic              root_vld;
    logic              root_sat;
    logic [ROOT_W-1:0] root_val;

    logic              done_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              sat_reg;
    logic              sat_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // lattice rows; writes to the unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ROW_A: row_reg[0] <= cfg_data;
                REG_ROW_B: row_reg[1] <= cfg_data;
                REG_ROW_C: row_reg[2] <= cfg_data;
                REG_NONE:  ;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_vld_reg <= 1'b0;
        end
        else
        begin
            img_vld_reg <= start && !busy;
        end
    end

    pmid_image u_img_x (.clk(clk), .center(center_x), .partner(partner_x), .delta_reg(delta[0]));
    pmid_image u_img_y (.clk(clk), .center(center_y), .partner(partner_y), .delta_reg(delta[1]));
    pmid_image u_img_z (.clk(clk), .center(center_z), .partner(partner_z), .delta_reg(delta[2]));

    pmid_cart u_cart (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (img_vld_reg),
        .delta     (delta),
        .rows      (row_reg),
        .out_valid (cart_vld),
        .mag       (cart_mag),
        .sat       (cart_sat)
    );

    pmid_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cart_vld),
        .mag       (cart_mag),
        .in_sat    (cart_sat),
        .out_valid (root_vld),
        .out_sat   (root_sat),
        .root      (root_val)
    );

    // root above the Q12.12 range also saturates
    assign sat_next = root_sat || (root_val[ROOT_W-1:DIST_W] != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= root_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg  <= sat_next;
        dist_reg <= sat_next ? '1 : root_val[DIST_W-1:0];
    end

    assign done      = done_reg;
    assign distance  = dist_reg;
    assign saturated = sat_reg;
endmodule

// ----- rtl/pmid_checker.sv -----
// Port-level checks for the distance pipeline, bound to the top level.
module pmid_checker
    import pmid_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              cfg_ready,
    input logic              done,
    input logic [DIST_W-1:0] distance,
    input logic              saturated
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> distance == '1)
        else $error("saturated result not clipped");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_LAT done)
        else $error("request lost in pipeline");
endmodule

bind periodic_min_image_distance_top pmid_checker u_pmid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .done      (done),
    .distance  (distance),
    .saturated (saturated)
);
